// ===== rtl/core/ssht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment/sphere hit test package
// Shared widths and stage flag types for the hit test pipeline.
// ----------------------------------------------------------------------------
package ssht_pkg;

   localparam int COORD_BITS  = 24;
   localparam int RADIUS_BITS = 23;

   // direction and offset components
   localparam int D_W   = COORD_BITS + 1;
   // products of two components
   localparam int PR_W  = 2 * D_W;
   // radius squared
   localparam int RR2_W = 2 * RADIUS_BITS;
   // sums of three products (len2, q, c)
   localparam int S_W   = ((PR_W > RR2_W + 1) ? PR_W : RR2_W + 1) + 2;
   // near and far root terms
   localparam int E_W   = S_W + 1;
   // wide multiplier split
   localparam int HALF_W = (E_W + 1) / 2;
   localparam int OP_W   = 2 * HALF_W;
   localparam int MP_W   = 2 * OP_W;
   // discriminant
   localparam int DS_W   = MP_W + 1;

   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(7680);

   typedef struct packed {
      logic valid;
      logic deg;
      logic qneg;
      logic cneg;
      logic cpos;
      logic eneg;
      logic fpos;
   } ssht_flags_type;

endpackage

// ===== rtl/core/ssht_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one segment and sphere centre.
// ----------------------------------------------------------------------------
interface ssht_req_if import ssht_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] start_z;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic signed [COORD_BITS-1:0] end_z;
   logic signed [COORD_BITS-1:0] center_x;
   logic signed [COORD_BITS-1:0] center_y;
   logic signed [COORD_BITS-1:0] center_z;

   modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   center_x, center_y, center_z, input ready);
   modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                 center_x, center_y, center_z, output ready);
endinterface

// ===== rtl/core/ssht_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the hit and degenerate flags.
// ----------------------------------------------------------------------------
interface ssht_rsp_if ();
   logic valid;
   logic ready;
   logic hit;
   logic degenerate;

   modport source (output valid, hit, degenerate, input ready);
   modport sink (input valid, hit, degenerate, output ready);
endinterface

// ===== rtl/core/segment_sphere_hit_test_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment/sphere hit test unit
// Reports whether a segment enters a sphere of the programmed radius.
// ----------------------------------------------------------------------------
// Takes one segment test per clock unless stalled and presents its result
// through eight register stages: four front stages (differences, products,
// sums, root terms), two stages of the split wide multipliers, one for the
// discriminant, then the root choice into the output register. The whole
// pipeline holds while a result waits on the response side; otherwise a new
// transaction enters each cycle.
// All arithmetic is exact integer, so no rounding enters the hit decision.
// ----------------------------------------------------------------------------
module segment_sphere_hit_test_unit import ssht_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   ssht_req_if.sink               req_chan,
   ssht_rsp_if.source             rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [RADIUS_BITS-1:0] csr_wr_data
);

   logic                   adv;
   logic [RADIUS_BITS-1:0] radius_ff;
   ssht_flags_type         flags;
   logic signed [OP_W-1:0] q_op, len2_op, c_op, e_op, f_op;
   logic signed [MP_W-1:0] qq, lc, ee, ff;
   logic                   out_valid;

   // advance whenever the output register is free or being drained
   assign adv            = !out_valid || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign rsp_chan.valid = out_valid;

   // radius register
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_wr_en) begin
         radius_ff <= csr_wr_data;
      end
   end

   ssht_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_chan.valid),
      .start_x  (req_chan.start_x),
      .start_y  (req_chan.start_y),
      .start_z  (req_chan.start_z),
      .end_x    (req_chan.end_x),
      .end_y    (req_chan.end_y),
      .end_z    (req_chan.end_z),
      .center_x (req_chan.center_x),
      .center_y (req_chan.center_y),
      .center_z (req_chan.center_z),
      .radius   (radius_ff),
      .flags    (flags),
      .q_op     (q_op),
      .len2_op  (len2_op),
      .c_op     (c_op),
      .e_op     (e_op),
      .f_op     (f_op)
   );

   ssht_wide_mul u_mul_qq (.clock(clock), .adv(adv), .a(q_op),    .b(q_op), .p(qq));
   ssht_wide_mul u_mul_lc (.clock(clock), .adv(adv), .a(len2_op), .b(c_op), .p(lc));
   ssht_wide_mul u_mul_ee (.clock(clock), .adv(adv), .a(e_op),    .b(e_op), .p(ee));
   ssht_wide_mul u_mul_ff (.clock(clock), .adv(adv), .a(f_op),    .b(f_op), .p(ff));

   ssht_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .flags     (flags),
      .qq        (qq),
      .lc        (lc),
      .ee        (ee),
      .ff        (ff),
      .out_valid (out_valid),
      .out_hit   (rsp_chan.hit),
      .out_deg   (rsp_chan.degenerate)
   );

endmodule

// ===== rtl/core/ssht_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Four stages: differences, component products, sums, root terms and signs.
// ----------------------------------------------------------------------------
module ssht_front import ssht_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic signed [COORD_BITS-1:0]  start_x,
   input  logic signed [COORD_BITS-1:0]  start_y,
   input  logic signed [COORD_BITS-1:0]  start_z,
   input  logic signed [COORD_BITS-1:0]  end_x,
   input  logic signed [COORD_BITS-1:0]  end_y,
   input  logic signed [COORD_BITS-1:0]  end_z,
   input  logic signed [COORD_BITS-1:0]  center_x,
   input  logic signed [COORD_BITS-1:0]  center_y,
   input  logic signed [COORD_BITS-1:0]  center_z,
   input  logic        [RADIUS_BITS-1:0] radius,
   output ssht_flags_type                flags,
   output logic signed [OP_W-1:0]        q_op,
   output logic signed [OP_W-1:0]        len2_op,
   output logic signed [OP_W-1:0]        c_op,
   output logic signed [OP_W-1:0]        e_op,
   output logic signed [OP_W-1:0]        f_op
);

   logic                    v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [D_W-1:0]   dx_ff, dy_ff, dz_ff, ox_ff, oy_ff, oz_ff;
   logic [RADIUS_BITS-1:0]  rr_ff;
   logic signed [PR_W-1:0]  pdd_x_ff, pdd_y_ff, pdd_z_ff;
   logic signed [PR_W-1:0]  pdo_x_ff, pdo_y_ff, pdo_z_ff;
   logic signed [PR_W-1:0]  poo_x_ff, poo_y_ff, poo_z_ff;
   logic [RR2_W-1:0]        rr2_ff;
   logic signed [S_W-1:0]   len2_ff, q_ff, c_ff;
   logic signed [S_W-1:0]   len2_in, q_in, c_in;
   logic signed [E_W-1:0]   e_in, f_in;
   ssht_flags_type          fl_ff, fl_in;
   logic signed [OP_W-1:0]  q4_ff, len24_ff, c4_ff, e4_ff, f4_ff;

   // advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // stage 1: direction and offset from the centre
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff <= D_W'(end_x) - D_W'(start_x);
         dy_ff <= D_W'(end_y) - D_W'(start_y);
         dz_ff <= D_W'(end_z) - D_W'(start_z);
         ox_ff <= D_W'(start_x) - D_W'(center_x);
         oy_ff <= D_W'(start_y) - D_W'(center_y);
         oz_ff <= D_W'(start_z) - D_W'(center_z);
         rr_ff <= radius;
      end
   end

   // stage 2: component products
   always_ff @(posedge clock) begin
      if (adv) begin
         pdd_x_ff <= dx_ff * dx_ff;
         pdd_y_ff <= dy_ff * dy_ff;
         pdd_z_ff <= dz_ff * dz_ff;
         pdo_x_ff <= dx_ff * ox_ff;
         pdo_y_ff <= dy_ff * oy_ff;
         pdo_z_ff <= dz_ff * oz_ff;
         poo_x_ff <= ox_ff * ox_ff;
         poo_y_ff <= oy_ff * oy_ff;
         poo_z_ff <= oz_ff * oz_ff;
         rr2_ff   <= RR2_W'(rr_ff) * RR2_W'(rr_ff);
      end
   end

   // stage 3: squared length, projection and offset term
   always_comb begin
      len2_in = S_W'(pdd_x_ff) + S_W'(pdd_y_ff) + S_W'(pdd_z_ff);
      q_in    = S_W'(pdo_x_ff) + S_W'(pdo_y_ff) + S_W'(pdo_z_ff);
      c_in    = S_W'(poo_x_ff) + S_W'(poo_y_ff) + S_W'(poo_z_ff)
              - $signed({{(S_W-RR2_W){1'b0}}, rr2_ff});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         len2_ff <= len2_in;
         q_ff    <= q_in;
         c_ff    <= c_in;
      end
   end

   // stage 4: near and far root terms and their signs
   always_comb begin
      e_in        = -E_W'(q_ff) - E_W'(len2_ff);
      f_in        = E_W'(len2_ff) + E_W'(q_ff);
      fl_in.valid = v3_ff;
      fl_in.deg   = (len2_ff == '0);
      fl_in.qneg  = q_ff[S_W-1];
      fl_in.cneg  = c_ff[S_W-1];
      fl_in.cpos  = !c_ff[S_W-1] && (c_ff != '0);
      fl_in.eneg  = e_in[E_W-1];
      fl_in.fpos  = !f_in[E_W-1] && (f_in != '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fl_ff    <= fl_in;
         q4_ff    <= OP_W'(q_ff);
         len24_ff <= OP_W'(len2_ff);
         c4_ff    <= OP_W'(c_ff);
         e4_ff    <= OP_W'(e_in);
         f4_ff    <= OP_W'(f_in);
      end
   end

   always_comb begin
      flags       = fl_ff;
      flags.valid = v4_ff;
   end

   assign q_op    = q4_ff;
   assign len2_op = len24_ff;
   assign c_op    = c4_ff;
   assign e_op    = e4_ff;
   assign f_op    = f4_ff;

endmodule

// ===== rtl/core/ssht_wide_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wide multiplier
// Two-stage signed multiply: four half-width partial products, then a sum.
// ----------------------------------------------------------------------------
module ssht_wide_mul import ssht_pkg::*; (
   input  logic                   clock,
   input  logic                   adv,
   input  logic signed [OP_W-1:0] a,
   input  logic signed [OP_W-1:0] b,
   output logic signed [MP_W-1:0] p
);

   logic [HALF_W-1:0]            al, bl;
   logic signed [HALF_W-1:0]     ah, bh;
   logic [2*HALF_W-1:0]          ll_ff;
   logic signed [2*HALF_W:0]     hl_ff, lh_ff;
   logic signed [2*HALF_W-1:0]   hh_ff;
   logic signed [MP_W-1:0]       p_ff, p_in;

   assign al = a[HALF_W-1:0];
   assign bl = b[HALF_W-1:0];
   assign ah = a[OP_W-1:HALF_W];
   assign bh = b[OP_W-1:HALF_W];

   // form the partial products
   always_ff @(posedge clock) begin
      if (adv) begin
         ll_ff <= al * bl;
         hl_ff <= (2*HALF_W+1)'(ah) * $signed({1'b0, bl});
         lh_ff <= $signed({1'b0, al}) * (2*HALF_W+1)'(bh);
         hh_ff <= ah * bh;
      end
   end

   // align and add the partial products
   always_comb begin
      p_in = (MP_W'(hh_ff) <<< (2*HALF_W))
           + ((MP_W'(hl_ff) + MP_W'(lh_ff)) <<< HALF_W)
           + $signed({{(MP_W-2*HALF_W){1'b0}}, ll_ff});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// ===== rtl/core/ssht_decide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Root decision
// Delay the flags past the multipliers, form the discriminant, pick the root
// and hold the result in the output register.
// ----------------------------------------------------------------------------
module ssht_decide import ssht_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  ssht_flags_type         flags,
   input  logic signed [MP_W-1:0] qq,
   input  logic signed [MP_W-1:0] lc,
   input  logic signed [MP_W-1:0] ee,
   input  logic signed [MP_W-1:0] ff,
   output logic                   out_valid,
   output logic                   out_hit,
   output logic                   out_deg
);

   ssht_flags_type          fl5_ff, fl6_ff, fl7_ff;
   logic signed [DS_W-1:0]  disc_ff, ee_ff, ff_ff;
   logic                    near, far, hit_in;
   logic                    v_ff, hit_ff, deg_ff;

   // hold the flags in step with the multiplier stages
   always_ff @(posedge clock) begin
      if (reset) begin
         fl5_ff.valid <= 1'b0;
         fl6_ff.valid <= 1'b0;
         fl7_ff.valid <= 1'b0;
         v_ff         <= 1'b0;
      end else if (adv) begin
         fl5_ff <= flags;
         fl6_ff <= fl5_ff;
         fl7_ff <= fl6_ff;
         v_ff   <= fl7_ff.valid;
      end
   end

   // discriminant stage
   always_ff @(posedge clock) begin
      if (adv) begin
         disc_ff <= DS_W'(qq) - DS_W'(lc);
         ee_ff   <= DS_W'(ee);
         ff_ff   <= DS_W'(ff);
      end
   end

   // pick the nearest positive root and test it against the length
   always_comb begin
      near   = fl7_ff.qneg && fl7_ff.cpos;
      far    = fl7_ff.qneg || fl7_ff.cneg;
      hit_in = 1'b0;
      if (!fl7_ff.deg && !disc_ff[DS_W-1]) begin
         if (near) begin
            hit_in = fl7_ff.eneg || (ee_ff < disc_ff);
         end else if (far) begin
            hit_in = fl7_ff.fpos && (disc_ff < ff_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= hit_in;
         deg_ff <= fl7_ff.deg;
      end
   end

   assign out_valid = v_ff;
   assign out_hit   = hit_ff;
   assign out_deg   = deg_ff;

endmodule

// ===== rtl/core/ssht_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hit test port checker
// Port-level checks on the hit test unit, attached by bind.
// ----------------------------------------------------------------------------
module ssht_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_hit,
   input logic rsp_deg
);

   // a degenerate segment never reports a hit
   a_deg_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_deg |-> !rsp_hit)
      else $error("hit reported on degenerate segment");

   // back-pressure only comes from a stalled response
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without response back-pressure");

   // nothing comes out just after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   // a stalled response holds its flags
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_deg))
      else $error("stalled response changed");

endmodule

bind segment_sphere_hit_test_unit ssht_checker u_ssht_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_hit   (rsp_chan.hit),
   .rsp_deg   (rsp_chan.degenerate)
);

// ===== tb/segment_sphere_hit_test_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment/sphere hit test unit testbench
// Drives segment tests through the request channel with random gaps, predicts
// hit and degenerate flags with exact wide integer arithmetic and checks each
// response in order, across several programmed radii.
// ----------------------------------------------------------------------------
module segment_sphere_hit_test_unit_tb;
   import ssht_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 30;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [255:0] wide_type;

   typedef struct packed {
      coord_type sx, sy, sz, ex, ey, ez, cx, cy, cz;
   } segment_type;

   typedef struct packed {
      logic hit;
      logic degenerate;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [RADIUS_BITS-1:0] csr_wr_data = '0;

   ssht_req_if req_chan ();
   ssht_rsp_if rsp_chan ();

   segment_sphere_hit_test_unit dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   verdict_type verdicts_due[$];
   logic [RADIUS_BITS-1:0] radius_now;
   int mismatches = 0;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predict the flags for one segment
   function automatic verdict_type predict_verdict(segment_type s,
                                                   logic [RADIUS_BITS-1:0] rad);
      wide_type dx, dy, dz, ox, oy, oz, len2, q, c, disc, rr, e, f;
      verdict_type v;
      dx = wide_type'(s.ex) - wide_type'(s.sx);
      dy = wide_type'(s.ey) - wide_type'(s.sy);
      dz = wide_type'(s.ez) - wide_type'(s.sz);
      ox = wide_type'(s.sx) - wide_type'(s.cx);
      oy = wide_type'(s.sy) - wide_type'(s.cy);
      oz = wide_type'(s.sz) - wide_type'(s.cz);
      v = '0;
      len2 = dx * dx + dy * dy + dz * dz;
      if (len2 == 0) begin
         v.degenerate = 1'b1;
         return v;
      end
      rr = wide_type'({1'b0, rad});
      q = dx * ox + dy * oy + dz * oz;
      c = ox * ox + oy * oy + oz * oz - rr * rr;
      disc = q * q - len2 * c;
      if (disc >= 0) begin
         if (q < 0 && c > 0) begin
            e = -q - len2;
            v.hit = (e < 0) || (e * e < disc);
         end else if (q < 0 || c < 0) begin
            f = len2 + q;
            v.hit = (f > 0) && (disc < f * f);
         end
      end
      return v;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // program a radius while idle
   task automatic write_radius(logic [RADIUS_BITS-1:0] rad);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rad;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      radius_now = rad;
   endtask

   // offer one transaction, dropping valid only across a gap
   task automatic send_segment(segment_type s);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.start_x  <= s.sx; req_chan.start_y  <= s.sy; req_chan.start_z  <= s.sz;
      req_chan.end_x    <= s.ex; req_chan.end_y    <= s.ey; req_chan.end_z    <= s.ez;
      req_chan.center_x <= s.cx; req_chan.center_y <= s.cy; req_chan.center_z <= s.cz;
      do @(posedge clock); while (!req_chan.ready);
      verdicts_due.push_back(predict_verdict(s, radius_now));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (verdicts_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic coord_type rand_coord(int span);
      if (span == 0) return coord_type'($urandom);
      return coord_type'($signed($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic segment_type rand_segment(int span);
      segment_type s;
      s.sx = rand_coord(span); s.sy = rand_coord(span); s.sz = rand_coord(span);
      s.ex = rand_coord(span); s.ey = rand_coord(span); s.ez = rand_coord(span);
      s.cx = rand_coord(span); s.cy = rand_coord(span); s.cz = rand_coord(span);
      // bias towards segments that pass near the centre
      if ($urandom_range(0, 1)) begin
         s.cx = coord_type'((s.sx + s.ex) / 2 + rand_coord(span / 8 + 1));
         s.cy = coord_type'((s.sy + s.ey) / 2 + rand_coord(span / 8 + 1));
         s.cz = coord_type'((s.sz + s.ez) / 2 + rand_coord(span / 8 + 1));
      end
      if ($urandom_range(0, 30) == 0) begin
         s.ex = s.sx; s.ey = s.sy; s.ez = s.sz;
      end
      return s;
   endfunction

   function automatic segment_type make_segment(int sx, int sy, int sz, int ex, int ey,
                                                int ez, int cx, int cy, int cz);
      segment_type s;
      s.sx = coord_type'(sx); s.sy = coord_type'(sy); s.sz = coord_type'(sz);
      s.ex = coord_type'(ex); s.ey = coord_type'(ey); s.ez = coord_type'(ez);
      s.cx = coord_type'(cx); s.cy = coord_type'(cy); s.cz = coord_type'(cz);
      return s;
   endfunction

   // directed corner cases at the reset radius of 30.0, then at zero and full-scale radii
   task automatic test_directed();
      int mx, mn;
      mx = 8388607; mn = -8388608;
      send_segment(make_segment(0, 0, 0, 0, 0, 0, 0, 0, 0));          // zero length
      send_segment(make_segment(mx, mn, mx, mx, mn, mx, 0, 0, 0));
      send_segment(make_segment(-25600, 0, 0, 25600, 0, 0, 0, 0, 0)); // through
      send_segment(make_segment(0, 0, 0, 25600, 0, 0, 0, 0, 0));      // start inside
      send_segment(make_segment(-25600, 7680, 0, 25600, 7680, 0, 0, 0, 0)); // tangent
      send_segment(make_segment(-25600, 0, 0, -7680, 0, 0, 0, 0, 0)); // ends on surface
      send_segment(make_segment(-7680, 0, 0, 25600, 0, 0, 0, 0, 0));  // starts on surface
      send_segment(make_segment(25600, 0, 0, 51200, 0, 0, 0, 0, 0));  // pointing away
      send_segment(make_segment(mn, mn, mn, mx, mx, mx, 0, 0, 0));
      send_segment(make_segment(mx, mx, mx, mn, mn, mn, mn, mn, mn));
      send_segment(make_segment(mn, mx, mn, mx, mn, mx, mx, mn, mx));
      send_segment(make_segment(-1, -1, -1, 0, 0, 0, mx, mx, mx));
      wait_drained();
      write_radius('0);
      send_segment(make_segment(-256, 0, 0, 256, 0, 0, 0, 0, 0));
      send_segment(make_segment(0, 0, 0, 256, 0, 0, 0, 0, 0));
      send_segment(make_segment(-256, 1, 0, 256, 1, 0, 0, 0, 0));
      wait_drained();
      write_radius({RADIUS_BITS{1'b1}});
      send_segment(make_segment(mn, mn, mn, mx, mx, mx, mx, mn, 0));
      send_segment(make_segment(mx, 0, 0, mx, 1, 0, mn, 0, 0));
      send_segment(make_segment(0, 0, 0, 1, 0, 0, 0, 0, 0));
      wait_drained();
   endtask

   // random segments across a radius
   task automatic test_random(logic [RADIUS_BITS-1:0] rad, int count);
      int span;
      write_radius(rad);
      repeat (count) begin
         case ($urandom_range(0, 3))
            0: span = 0;
            1: span = 40000;
            2: span = 2000;
            default: span = 300000;
         endcase
         send_segment(rand_segment(span));
      end
      wait_drained();
   endtask

   // hold the response side off so the pipeline fills and stalls
   task automatic test_backpressure();
      int k;
      write_radius(23'd7680);
      hold_rsp = 1'b1;
      fork
         begin
            repeat (200) @(negedge clock);
            hold_rsp = 1'b0;
         end
         for (k = 0; k < 40; k++) send_segment(rand_segment(40000));
      join
      wait_drained();
   endtask

   // response sink with random stalls
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = $urandom_range(0, 4);
         if (stall != 0 || hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
            while (hold_rsp) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // check each response against the oldest prediction
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (verdicts_due.size() == 0) begin
            report_mismatch("response with no transaction outstanding");
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_chan.hit !== want.hit)
               report_mismatch($sformatf("hit %b, want %b", rsp_chan.hit, want.hit));
            if (rsp_chan.degenerate !== want.degenerate)
               report_mismatch($sformatf("degenerate %b, want %b",
                                         rsp_chan.degenerate, want.degenerate));
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.start_x = '0; req_chan.start_y = '0; req_chan.start_z = '0;
      req_chan.end_x = '0; req_chan.end_y = '0; req_chan.end_z = '0;
      req_chan.center_x = '0; req_chan.center_y = '0; req_chan.center_z = '0;
      radius_now = RADIUS_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(23'd7680, 400);
      test_backpressure();
      test_random('0, 150);
      test_random({RADIUS_BITS{1'b1}}, 200);
      test_random(23'd1000000, 300);
      test_random(23'($urandom), 300);
      if (verdicts_due.size() == 0 && mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
